// ----- rtl/bsm_pkg.sv -----
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types, operation codes and constants for the byte stack machine.
// ----------------------------------------------------------------------------
package bsm_pkg;

   localparam int STACK_DEPTH_DEF = 256;
   localparam int DATA_DEPTH_DEF  = 128;
   localparam int NUM_VARS        = 26;

   typedef enum logic [4:0] {
      OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
      OP_DROP = 5'd5, OP_DUP = 5'd6, OP_SWAP = 5'd7, OP_ROT = 5'd8, OP_OVER = 5'd9,
      OP_PICK = 5'd10, OP_AND = 5'd11, OP_OR = 5'd12, OP_XOR = 5'd13, OP_NOT = 5'd14,
      OP_EQ = 5'd15, OP_LESS = 5'd16, OP_GREATER = 5'd17, OP_PRINT_INT = 5'd18,
      OP_PRINT_CHAR = 5'd19, OP_SKIP_TRUE = 5'd20, OP_SKIP_FALSE = 5'd21,
      OP_STORE = 5'd22, OP_LOAD = 5'd23
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_OVERFLOW = 3'd2, ST_BAD_INDEX = 3'd3,
      ST_DIV_ZERO = 3'd4
   } status_type;

   localparam logic [1:0] PK_NONE = 2'd0;
   localparam logic [1:0] PK_INT  = 2'd1;
   localparam logic [1:0] PK_CHAR = 2'd2;

   // decoded item handed from front to back
   typedef struct packed {
      logic [4:0]       op;
      logic             known;
      logic [1:0]       need;
      logic             grows;
      logic signed [7:0] lit;
   } dec_type;

endpackage

// ----- rtl/bsm_ram.sv -----
// ----------------------------------------------------------------------------
// bsm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- rtl/bsm_front.sv -----
// ----------------------------------------------------------------------------
// bsm_front
// Accepts items, decodes operand needs and growth, and queues them (2 deep).
// ----------------------------------------------------------------------------
module bsm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [4:0]            req_operation,
   input  logic signed [7:0]     req_literal,
   output logic                  q_valid,
   input  logic                  q_take,
   output bsm_pkg::dec_type      q_item
);
   import bsm_pkg::*;

   dec_type   slot_ff [2];
   logic      rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   dec_type   dec;

   always_comb begin
      dec       = '0;
      dec.op    = req_operation;
      dec.lit   = req_literal;
      dec.known = (req_operation <= OP_LOAD);
      unique case (req_operation) inside
         OP_PUSH:                         dec.grows = 1'b1;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_AND, OP_OR, OP_XOR,
         OP_EQ, OP_LESS, OP_GREATER, OP_STORE: dec.need = 2'd2;
         OP_OVER: begin
            dec.need  = 2'd2;
            dec.grows = 1'b1;
         end
         OP_ROT:                          dec.need = 2'd3;
         OP_DUP: begin
            dec.need  = 2'd1;
            dec.grows = 1'b1;
         end
         OP_DROP, OP_PICK, OP_NOT, OP_PRINT_INT, OP_PRINT_CHAR, OP_SKIP_TRUE,
         OP_SKIP_FALSE, OP_LOAD:          dec.need = 2'd1;
         default:                         dec.need = 2'd0;
      endcase
   end

   logic do_wr;
   assign req_full = (cnt_ff == 2'd2);
   assign do_wr    = req_push && !req_full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ff] <= dec;
      end
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_wr) wr_ff <= ~wr_ff;
         if (q_take) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(do_wr) - 2'(q_take);
      end
   end
endmodule

// ----- rtl/bsm_divider.sv -----
// ----------------------------------------------------------------------------
// bsm_divider
// Signed 8-bit divider, truncating, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsm_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic signed [7:0] dividend,
   input  logic signed [7:0] divisor,
   output logic              done,
   output logic [7:0]        quotient
);
   logic [7:0] num_ff, den_ff, q_ff;
   logic [8:0] rem_ff;
   logic [3:0] cnt_ff;
   logic       neg_ff, busy_ff;
   logic [8:0] trial;

   assign trial    = {rem_ff[7:0], num_ff[7]} - {1'b0, den_ff};
   assign done     = busy_ff && (cnt_ff == 4'd0);
   assign quotient = neg_ff ? 8'(-q_ff) : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 4'd8;
         num_ff  <= dividend[7] ? 8'(-dividend) : dividend;
         den_ff  <= divisor[7] ? 8'(-divisor) : divisor;
         neg_ff  <= dividend[7] ^ divisor[7];
         rem_ff  <= '0;
         q_ff    <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == 4'd0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 4'd1;
            num_ff <= {num_ff[6:0], 1'b0};
            if (!trial[8]) begin
               rem_ff <= trial;
               q_ff   <= {q_ff[6:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[7:0], num_ff[7]};
               q_ff   <= {q_ff[6:0], 1'b0};
            end
         end
      end
   end
endmodule

// ----- rtl/bsm_back.sv -----
// ----------------------------------------------------------------------------
// bsm_back
// Executes queued operations against the stack, variables and data array.
// Top and second are cached in registers; deeper entries live in RAM.
// ----------------------------------------------------------------------------
module bsm_back #(
   parameter int STACK_DEPTH = bsm_pkg::STACK_DEPTH_DEF,
   parameter int DATA_DEPTH  = bsm_pkg::DATA_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_take,
   input  bsm_pkg::dec_type          q_item,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [2:0]                rsp_status,
   output logic signed [7:0]         rsp_top_value,
   output logic [8:0]                rsp_stack_count,
   output logic [1:0]                rsp_print_kind,
   output logic signed [7:0]         rsp_print_value,
   output logic                      rsp_skip_next
);
   import bsm_pkg::*;

   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int PW  = (CW > 8) ? CW : 8;
   localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int CLRN = (DATA_DEPTH > NUM_VARS) ? DATA_DEPTH : NUM_VARS;
   localparam int CLW  = $clog2(CLRN + 1);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001, S_IDLE = 8'b00000010, S_RD = 8'b00000100,
      S_EXEC  = 8'b00001000, S_DIV  = 8'b00010000, S_WR = 8'b00100000,
      S_OUT   = 8'b01000000, S_FILL = 8'b10000000
   } state_type;

   state_type  state_ff;
   dec_type    it_ff;
   logic [CW-1:0] n_ff;
   logic [7:0] t_ff, s_ff;
   logic [CLW-1:0] clr_ff;
   logic [2:0] st_ff;
   logic [1:0] pk_ff;
   logic [7:0] pv_ff;
   logic       sk_ff;
   logic       out_ff;

   // stack RAM holds entries below the cached top two
   logic           sw_en;
   logic [SAW-1:0] sw_addr, sr_addr;
   logic [7:0]     sw_data, sr_data;
   logic           vw_en;
   logic [4:0]     vw_addr, vr_addr;
   logic [7:0]     vw_data, vr_data;
   logic           dw_en;
   logic [DAW-1:0] dw_addr, dr_addr;
   logic [7:0]     dw_data, dr_data;

   bsm_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en(sw_en), .wr_addr(sw_addr), .wr_data(sw_data),
      .rd_addr(sr_addr), .rd_data(sr_data));
   bsm_ram #(.WIDTH(8), .DEPTH(32)) u_vars (
      .clock, .wr_en(vw_en), .wr_addr(vw_addr), .wr_data(vw_data),
      .rd_addr(vr_addr), .rd_data(vr_data));
   bsm_ram #(.WIDTH(8), .DEPTH(1 << DAW)) u_data (
      .clock, .wr_en(dw_en), .wr_addr(dw_addr), .wr_data(dw_data),
      .rd_addr(dr_addr), .rd_data(dr_data));

   logic div_start, div_done;
   logic [7:0] div_q;
   bsm_divider u_div (
      .clock, .reset, .start(div_start), .dividend(s_ff), .divisor(t_ff),
      .done(div_done), .quotient(div_q));

   // address resolution for store/load
   logic is_var, is_dat, addr_ok;
   assign is_var  = (t_ff >= 8'd97) && (t_ff <= 8'd122);
   assign is_dat  = t_ff[7] && ({1'b0, t_ff[6:0]} < 8'(DATA_DEPTH));
   assign addr_ok = is_var || is_dat;

   logic [CW-1:0] nm1, nm2, nm3;
   assign nm1 = n_ff - CW'(1);
   assign nm2 = n_ff - CW'(2);
   assign nm3 = n_ff - CW'(3);

   logic err_pre;
   assign err_pre = (n_ff < CW'(it_ff.need)) ||
                    (it_ff.grows && (n_ff >= CW'(STACK_DEPTH)));

   logic pick_neg, pick_big;
   assign pick_neg = t_ff[7];
   assign pick_big = (PW'(t_ff[6:0]) >= PW'(nm1));

   assign q_take    = (state_ff == S_IDLE) && q_valid;
   assign div_start = (state_ff == S_EXEC) && !err_pre && it_ff.op == OP_DIV &&
                      t_ff != 8'd0;

   logic rsp_load;
   assign rsp_load = (state_ff == S_OUT) && (!out_ff || rsp_pop);

   // read addresses, used in S_RD and, for the refill, in S_FILL
   always_comb begin
      sr_addr = SAW'(nm3);
      if (it_ff.op == OP_PICK) begin
         sr_addr = SAW'(PW'(nm2) - PW'(t_ff[6:0]));
      end else if (state_ff == S_FILL) begin
         sr_addr = SAW'(nm2);
      end
      vr_addr = 5'(t_ff - 8'd97);
      dr_addr = DAW'(t_ff[6:0]);
   end

   always_comb begin
      sw_en   = 1'b0;
      sw_addr = SAW'(nm2);
      sw_data = s_ff;
      vw_en   = (state_ff == S_CLEAR) && (clr_ff < CLW'(NUM_VARS));
      vw_addr = 5'(clr_ff);
      vw_data = 8'd0;
      dw_en   = (state_ff == S_CLEAR) && (clr_ff < CLW'(DATA_DEPTH));
      dw_addr = DAW'(clr_ff);
      dw_data = 8'd0;
      if (state_ff == S_EXEC && !err_pre) begin
         unique case (it_ff.op) inside
            OP_PUSH, OP_DUP, OP_OVER: sw_en = (n_ff >= CW'(2));
            OP_ROT: begin
               sw_en   = 1'b1;
               sw_addr = SAW'(nm3);
            end
            OP_STORE: begin
               vw_en   = is_var;
               vw_addr = 5'(t_ff - 8'd97);
               vw_data = s_ff;
               dw_en   = is_dat;
               dw_addr = DAW'(t_ff[6:0]);
               dw_data = s_ff;
            end
            default: ;
         endcase
      end
   end

   logic [7:0] sum, dif, prd;
   assign sum = s_ff + t_ff;
   assign dif = s_ff - t_ff;
   assign prd = 8'(s_ff * t_ff);

   assign rsp_empty = !out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         n_ff     <= '0;
         out_ff   <= 1'b0;
      end else begin
         if (rsp_load) out_ff <= 1'b1;
         else if (rsp_pop) out_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CLW'(1);
               if (clr_ff == CLW'(CLRN - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_valid) begin
                  it_ff    <= q_item;
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_EXEC;
            S_EXEC: begin
               st_ff <= ST_OK;
               pk_ff <= PK_NONE;
               pv_ff <= 8'd0;
               sk_ff <= 1'b0;
               state_ff <= S_OUT;
               if (err_pre) begin
                  st_ff <= (n_ff < CW'(it_ff.need)) ? ST_UNDERFLOW : ST_OVERFLOW;
               end else if (it_ff.known) begin
                  unique case (it_ff.op) inside
                     OP_PUSH: begin
                        s_ff <= t_ff; t_ff <= it_ff.lit; n_ff <= n_ff + CW'(1);
                     end
                     OP_DUP: begin
                        s_ff <= t_ff; n_ff <= n_ff + CW'(1);
                     end
                     OP_OVER: begin
                        s_ff <= t_ff; t_ff <= s_ff; n_ff <= n_ff + CW'(1);
                     end
                     OP_ADD: begin
                        t_ff <= sum; n_ff <= nm1; state_ff <= S_FILL;
                     end
                     OP_SUB: begin
                        t_ff <= dif; n_ff <= nm1; state_ff <= S_FILL;
                     end
                     OP_MUL: begin
                        t_ff <= prd; n_ff <= nm1; state_ff <= S_FILL;
                     end
                     OP_AND: begin
                        t_ff <= s_ff & t_ff; n_ff <= nm1; state_ff <= S_FILL;
                     end
                     OP_OR: begin
                        t_ff <= s_ff | t_ff; n_ff <= nm1; state_ff <= S_FILL;
                     end
                     OP_XOR: begin
                        t_ff <= s_ff ^ t_ff; n_ff <= nm1; state_ff <= S_FILL;
                     end
                     OP_DIV: begin
                        if (t_ff == 8'd0) st_ff <= ST_DIV_ZERO;
                        else state_ff <= S_DIV;
                     end
                     OP_DROP, OP_PRINT_CHAR: begin
                        if (it_ff.op == OP_PRINT_CHAR) begin
                           pk_ff <= PK_CHAR; pv_ff <= t_ff;
                        end
                        t_ff <= s_ff; n_ff <= nm1;
                        state_ff <= S_FILL;
                     end
                     OP_SWAP: begin
                        t_ff <= s_ff; s_ff <= t_ff;
                     end
                     OP_ROT: begin
                        t_ff <= sr_data; s_ff <= t_ff;
                     end
                     OP_PICK: begin
                        if (pick_neg) st_ff <= ST_OVERFLOW;
                        else if (pick_big) st_ff <= ST_UNDERFLOW;
                        else if (t_ff[6:0] == 7'd0) t_ff <= s_ff;
                        else t_ff <= sr_data;
                     end
                     OP_NOT:     t_ff <= ~t_ff;
                     OP_EQ:      t_ff <= {8{s_ff == t_ff}};
                     OP_LESS:    t_ff <= {8{$signed(t_ff) < $signed(s_ff)}};
                     OP_GREATER: t_ff <= {8{$signed(t_ff) > $signed(s_ff)}};
                     OP_PRINT_INT: begin
                        pk_ff <= PK_INT; pv_ff <= t_ff;
                     end
                     OP_SKIP_TRUE:  sk_ff <= (t_ff != 8'd0);
                     OP_SKIP_FALSE: sk_ff <= (t_ff == 8'd0);
                     OP_STORE: begin
                        if (!addr_ok) st_ff <= ST_BAD_INDEX;
                        else begin
                           t_ff <= s_ff; n_ff <= nm1; state_ff <= S_FILL;
                        end
                     end
                     OP_LOAD: begin
                        if (!addr_ok) st_ff <= ST_BAD_INDEX;
                        else t_ff <= is_var ? vr_data : dr_data;
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV: begin
               if (div_done) begin
                  t_ff <= div_q; n_ff <= nm1; state_ff <= S_FILL;
               end
            end
            S_FILL: state_ff <= S_WR;
            S_WR: begin
               s_ff <= sr_data;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_status      <= st_ff;
                  rsp_top_value   <= (n_ff != '0) ? t_ff : 8'd0;
                  rsp_stack_count <= 9'(n_ff);
                  rsp_print_kind  <= pk_ff;
                  rsp_print_value <= pv_ff;
                  rsp_skip_next   <= sk_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/byte_stack_machine_execute.sv -----
// ----------------------------------------------------------------------------
// byte_stack_machine_execute
// Signed 8-bit stack machine: one decoded operation per item, one result each.
// ----------------------------------------------------------------------------
// A two-entry queue decouples intake from execution. Each item passes the executor
// states in order: take from the queue, read of the third stack entry, execute,
// result; when it pops, a refill of the cached second entry from the stack RAM
// comes before the result, and a divide first waits on the bit-serial divider.
// The executor holds in its result state while a result waits unread. After
// reset a clearing pass over the variables and data array runs, during which
// items queue but do not execute.
module byte_stack_machine_execute #(
   parameter int STACK_DEPTH = bsm_pkg::STACK_DEPTH_DEF,
   parameter int DATA_DEPTH  = bsm_pkg::DATA_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [4:0]        req_operation,
   input  logic signed [7:0] req_literal,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [2:0]        rsp_status,
   output logic signed [7:0] rsp_top_value,
   output logic [8:0]        rsp_stack_count,
   output logic [1:0]        rsp_print_kind,
   output logic signed [7:0] rsp_print_value,
   output logic              rsp_skip_next
);
   import bsm_pkg::*;

   logic    q_valid, q_take;
   dec_type q_item;

   bsm_front u_front (
      .clock, .reset, .req_push, .req_full, .req_operation, .req_literal,
      .q_valid, .q_take, .q_item);

   bsm_back #(.STACK_DEPTH(STACK_DEPTH), .DATA_DEPTH(DATA_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_item, .rsp_empty, .rsp_pop,
      .rsp_status, .rsp_top_value, .rsp_stack_count, .rsp_print_kind,
      .rsp_print_value, .rsp_skip_next);

`ifndef NO_ASSERTIONS
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status <= ST_DIV_ZERO) else $error("status out of range");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_stack_count <= 9'(STACK_DEPTH)) else $error("count too big");
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status != ST_OK |-> rsp_print_kind == PK_NONE && !rsp_skip_next)
      else $error("error with side output");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("queue underrun");
`endif
endmodule
